FILE: rtl/pmt_pkg.sv
package pmt_pkg;

  // result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PCR    = 2'd1;
  localparam logic [1:0] KIND_STREAM = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  // end of section status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_SHORT       = 3'd1;
  localparam logic [2:0] ST_INVALID_END = 3'd2;
  localparam logic [2:0] ST_TRUNCATED   = 3'd3;
  localparam logic [2:0] ST_REJECTED    = 3'd4;

  // flag bit positions
  localparam int FL_CRC      = 0;
  localparam int FL_MISMATCH = 1;
  localparam int FL_LEFTOVER = 2;

  // configuration register indexes
  localparam logic CFG_MATCH_PROGRAM = 1'b0;
  localparam logic CFG_MATCH_ENABLE  = 1'b1;

  localparam logic [7:0]  TABLE_ID_PMT = 8'h02;
  localparam logic [31:0] CRC_POLY     = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;

  // parser phases
  typedef enum logic [7:0] {
    PH_HEADER = 8'b0000_0001,
    PH_PCR    = 8'b0000_0010,
    PH_PINFO  = 8'b0000_0100,
    PH_PSKIP  = 8'b0000_1000,
    PH_ENTRY  = 8'b0001_0000,
    PH_ESSKIP = 8'b0010_0000,
    PH_TAIL   = 8'b0100_0000,
    PH_REJECT = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tbl_id;
    logic [15:0] prog_num;
    logic [4:0]  version;
    logic        current_next;
    logic [7:0]  sect_num;
    logic [7:0]  last_sect_num;
    logic [12:0] pid;
    logic [7:0]  strm_type;
    logic [11:0] info_length;
    logic [2:0]  status;
    logic [2:0]  flags;
  } result_t;

  // up to two results per byte; second only when first is present
  typedef struct packed {
    logic    first_valid;
    result_t first;
    logic    second_valid;
    result_t second;
  } push_t;

  // crc-32/mpeg-2, one byte, msb first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {b, 24'h0};
    for (int i = 0; i < 8; i++) begin
      c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/pmt_core.sv
module pmt_core
  import pmt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic [7:0]  byte_in,
  input  logic [12:0] sb_in,
  input  logic [15:0] match_program,
  input  logic        match_enable,
  output push_t       push
);

  logic [12:0] pos, pos_next;
  phase_t      phase, phase_next;
  logic [11:0] skip, skip_next;
  logic [12:0] body, body_next;
  logic [31:0] crc, crc_next;
  logic [7:0]  fb [4];
  logic [7:0]  fb_next [4];
  logic [11:0] hlen, hlen_next;
  logic [2:0]  pend, pend_next;
  logic        mismatch, mismatch_next;
  logic        leftover, leftover_next;

  result_t     m, e;
  logic        m_valid, e_valid;

  // parse one byte
  always_comb begin
    logic [13:0] count;
    logic [12:0] body_dec;
    logic [11:0] len;
    logic [11:0] sk;
    logic        do_loop;

    count    = {1'b0, pos} + 14'd1;
    body_dec = (body != 13'd0) ? body - 13'd1 : body;
    len      = '0;
    sk       = '0;
    do_loop  = 1'b0;

    crc_next      = crc_byte(crc, byte_in);
    pos_next      = pos;
    phase_next    = phase;
    skip_next     = skip;
    body_next     = body;
    fb_next       = fb;
    hlen_next     = hlen;
    pend_next     = pend;
    mismatch_next = mismatch;
    leftover_next = leftover;
    m             = '0;
    m_valid       = 1'b0;
    e             = '0;
    e_valid       = 1'b0;

    case (phase)
      PH_HEADER: begin
        case (pos)
          13'd0: fb_next[0] = byte_in;
          13'd1: hlen_next = {byte_in[3:0], 8'h00};
          13'd2: hlen_next = {hlen[11:8], byte_in};
          13'd3: fb_next[1] = byte_in;
          13'd4: begin
            fb_next[2] = byte_in;
            if (match_enable &&
                (fb[0] != TABLE_ID_PMT || {fb[1], byte_in} != match_program)) begin
              phase_next = PH_REJECT;
            end
          end
          13'd5: fb_next[3] = byte_in;
          13'd6: skip_next = {4'h0, byte_in};
          default: begin
            m_valid         = 1'b1;
            m.kind          = KIND_HEADER;
            m.tbl_id        = fb[0];
            m.prog_num      = {fb[1], fb[2]};
            m.version       = fb[3][5:1];
            m.current_next  = fb[3][0];
            m.sect_num      = skip[7:0];
            m.last_sect_num = byte_in;
            if ({1'b0, hlen} + 13'd3 != sb_in) begin
              mismatch_next = 1'b1;
            end
            skip_next = '0;
            body_next = '0;
            if (sb_in < 13'd14) begin
              pend_next  = ST_INVALID_END;
              phase_next = PH_TAIL;
            end else begin
              body_next  = sb_in - 13'd12;
              phase_next = PH_PCR;
            end
          end
        endcase
      end
      PH_PCR: begin
        body_next = body_dec;
        if (skip == 12'd0) begin
          fb_next[0] = byte_in;
          skip_next  = 12'd1;
        end else begin
          m_valid   = 1'b1;
          m.kind    = KIND_PCR;
          m.pid     = {fb[0][4:0], byte_in};
          skip_next = '0;
          if (body_dec < 13'd2) begin
            pend_next  = ST_INVALID_END;
            phase_next = PH_TAIL;
          end else begin
            phase_next = PH_PINFO;
          end
        end
      end
      PH_PINFO: begin
        body_next = body_dec;
        if (skip == 12'd0) begin
          fb_next[0] = byte_in;
          skip_next  = 12'd1;
        end else begin
          len = {fb[0][3:0], byte_in};
          if (body_dec < {1'b0, len}) begin
            pend_next  = ST_TRUNCATED;
            skip_next  = '0;
            phase_next = PH_TAIL;
          end else if (len != 12'd0) begin
            skip_next  = len;
            phase_next = PH_PSKIP;
          end else begin
            do_loop = 1'b1;
          end
        end
      end
      PH_ENTRY: begin
        body_next = body_dec;
        if (skip < 12'd4) begin
          fb_next[skip[1:0]] = byte_in;
          skip_next          = skip + 12'd1;
        end else begin
          len           = {fb[3][3:0], byte_in};
          m_valid       = 1'b1;
          m.kind        = KIND_STREAM;
          m.pid         = {fb[1][4:0], fb[2]};
          m.strm_type   = fb[0];
          m.info_length = len;
          if (body_dec < {1'b0, len}) begin
            pend_next  = ST_TRUNCATED;
            skip_next  = '0;
            phase_next = PH_TAIL;
          end else if (len != 12'd0) begin
            skip_next  = len;
            phase_next = PH_ESSKIP;
          end else begin
            do_loop = 1'b1;
          end
        end
      end
      PH_PSKIP, PH_ESSKIP: begin
        body_next = body_dec;
        sk        = (skip != 12'd0) ? skip - 12'd1 : skip;
        skip_next = sk;
        if (sk == 12'd0) begin
          do_loop = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // next stream entry or end of loop
    if (do_loop) begin
      skip_next = '0;
      if (body_dec >= 13'd5) begin
        phase_next = PH_ENTRY;
      end else begin
        if (body_dec != 13'd0) begin
          leftover_next = 1'b1;
        end
        phase_next = PH_TAIL;
      end
    end

    // last byte of the section
    if (count >= {1'b0, sb_in}) begin
      e_valid = 1'b1;
      e.kind  = KIND_END;
      if (count < 14'd8) begin
        e.status = ST_SHORT;
      end else if (phase_next == PH_REJECT) begin
        e.status = ST_REJECTED;
      end else begin
        e.status            = pend_next;
        e.flags[FL_CRC]      = (count >= 14'd12) && (crc_next != 32'd0);
        e.flags[FL_MISMATCH] = mismatch_next;
        e.flags[FL_LEFTOVER] = leftover_next;
      end
      pos_next      = '0;
      phase_next    = PH_HEADER;
      skip_next     = '0;
      body_next     = '0;
      crc_next      = CRC_INIT;
      hlen_next     = '0;
      pend_next     = ST_OK;
      mismatch_next = 1'b0;
      leftover_next = 1'b0;
    end else begin
      pos_next = count[12:0];
    end
  end

  // order the results
  always_comb begin
    push = '0;
    if (m_valid) begin
      push.first_valid  = 1'b1;
      push.first        = m;
      push.second_valid = e_valid;
      push.second       = e;
    end else begin
      push.first_valid = e_valid;
      push.first       = e;
    end
    if (!advance) begin
      push.first_valid  = 1'b0;
      push.second_valid = 1'b0;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      phase    <= PH_HEADER;
      skip     <= '0;
      body     <= '0;
      crc      <= CRC_INIT;
      hlen     <= '0;
      pend     <= ST_OK;
      mismatch <= 1'b0;
      leftover <= 1'b0;
    end else if (advance) begin
      pos      <= pos_next;
      phase    <= phase_next;
      skip     <= skip_next;
      body     <= body_next;
      crc      <= crc_next;
      hlen     <= hlen_next;
      pend     <= pend_next;
      mismatch <= mismatch_next;
      leftover <= leftover_next;
    end
  end

  // field bytes, no reset
  always_ff @(posedge clk) begin
    if (advance) begin
      fb <= fb_next;
    end
  end

  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    push.second_valid |-> push.first_valid)
    else $error("second result without a first");

  a_second_is_end: assert property (@(posedge clk) disable iff (rst)
    push.second_valid |-> push.second.kind == KIND_END)
    else $error("second result is not an end of section");

  a_restart_after_end: assert property (@(posedge clk) disable iff (rst)
    (advance && e_valid) |=> (pos == 13'd0 && crc == CRC_INIT && phase == PH_HEADER))
    else $error("parser did not restart after end of section");

endmodule

FILE: rtl/pmt_out_fifo.sv
module pmt_out_fifo
  import pmt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  input  logic    pop,
  output result_t head,
  output logic    nonempty,
  output logic    room
);

  localparam int DEPTH = 4;

  result_t     mem [DEPTH];
  logic [1:0]  wp, rp;
  logic [2:0]  count, count_next;
  logic [2:0]  push_n;

  assign push_n   = {2'b00, push.first_valid} + {2'b00, push.second_valid};
  assign nonempty = (count != 3'd0);
  assign room     = (count <= 3'd2);
  assign head     = mem[rp];

  always_comb begin
    count_next = count + push_n - {2'b00, pop};
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + push_n[1:0];
      rp    <= rp + {1'b0, pop};
      count <= count_next;
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (push.first_valid) begin
      mem[wp] <= push.first;
    end
    if (push.second_valid) begin
      mem[wp + 2'd1] <= push.second;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push_n != 3'd0) |-> ({1'b0, count} + {1'b0, push_n} <= 4'd4))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != 3'd0)
    else $error("result queue underflow");

endmodule

FILE: rtl/pmt_section_parser.sv
// Program map section parser. Section bytes enter one per cycle, unless
// stalled, on the in_valid/in_stall channel, each with the stored section
// length, and the block returns header, PCR PID, stream entry and end of
// section results on the out_valid/out_stall channel. Every byte passes an
// input register and the combinational parsing and CRC-32 logic, then lands
// in a four-entry result queue, so a byte is taken every cycle while input
// is not stalled; results leave from the head of the queue. The last byte
// of a section can give two results (a header, PCR PID or stream entry and
// the end result); those enter the queue together and leave one after the
// other, and input stalls only while the queue holds three or more results.
// The match registers are written on the cfg port and must be set while the
// block is idle.
module pmt_section_parser
  import pmt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // section bytes
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic [12:0] section_bytes,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  tbl_id,
  output logic [15:0] prog_num,
  output logic [4:0]  version,
  output logic        current_next,
  output logic [7:0]  sect_num,
  output logic [7:0]  last_sect_num,
  output logic [12:0] pid,
  output logic [7:0]  strm_type,
  output logic [11:0] info_length,
  output logic [2:0]  status,
  output logic [2:0]  flags
);

  logic [15:0] match_program;
  logic        match_enable;
  logic        stage_valid;
  logic [7:0]  stage_byte;
  logic [12:0] stage_sb;
  logic        room;
  logic        advance;
  logic        accept;
  push_t       push;
  result_t     head;

  assign cfg_ready = 1'b1;
  assign advance   = stage_valid && room;
  assign in_stall  = stage_valid && !room;
  assign accept    = in_valid && !in_stall;

  // match registers
  always_ff @(posedge clk) begin
    if (rst) begin
      match_program <= '0;
      match_enable  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MATCH_PROGRAM: match_program <= cfg_data;
        CFG_MATCH_ENABLE:  match_enable  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_byte <= data_byte;
      stage_sb   <= section_bytes;
    end
  end

  pmt_core u_core (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .byte_in       (stage_byte),
    .sb_in         (stage_sb),
    .match_program (match_program),
    .match_enable  (match_enable),
    .push          (push)
  );

  pmt_out_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pop      (out_valid && !out_stall),
    .head     (head),
    .nonempty (out_valid),
    .room     (room)
  );

  assign kind          = head.kind;
  assign tbl_id        = head.tbl_id;
  assign prog_num      = head.prog_num;
  assign version       = head.version;
  assign current_next  = head.current_next;
  assign sect_num      = head.sect_num;
  assign last_sect_num = head.last_sect_num;
  assign pid           = head.pid;
  assign strm_type     = head.strm_type;
  assign info_length   = head.info_length;
  assign status        = head.status;
  assign flags         = head.flags;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (stage_valid && !room))
    else $error("input stalled with free queue space");

endmodule
